// ===== rtl/core/url_percent_decoder_defines.svh =====
// assertion macros shared by the url percent decoder rtl
`ifndef URL_PERCENT_DECODER_DEFINES_SVH
`define URL_PERCENT_DECODER_DEFINES_SVH

// same-cycle implication, sampled on the block clock, off during reset
`define UPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the block clock, off during reset
`define UPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/upd_pkg.sv =====
// types, constants and helper functions for the url percent decoder
`timescale 1ns / 1ps
`default_nettype none

package upd_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLUS_AS_SPACE = 1'b0,
        CFG_STOP_MODE     = 1'b1
    } t_cfg_idx;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;

    // bytes held of an open escape sequence
    typedef enum logic [1:0] {
        HELD_NONE    = 2'd0,
        HELD_PCT     = 2'd1,
        HELD_PCT_HEX = 2'd2
    } t_held;

    // one result as it leaves the block, run_last added by the back end
    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       token_end;
    } t_res;

    // all results of one request, packed from entry 0 up to entry last
    typedef struct packed {
        t_res [2:0] res;
        logic [1:0] last;
    } t_cmd;

    function automatic logic is_hex(input logic [7:0] c);
        logic dig;
        logic low;
        logic upp;
        dig = (c >= 8'h30) && (c <= 8'h39);
        low = (c >= 8'h61) && (c <= 8'h66);
        upp = (c >= 8'h41) && (c <= 8'h46);
        return dig || low || upp;
    endfunction

    // valid only for hex digits; letters of both cases share the low nibble
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] val;
        if (c <= 8'h39) begin
            val = c[3:0];
        end else begin
            val = c[3:0] + 4'd9;
        end
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/upd_front.sv =====
// front end: classifies each byte, tracks the open escape, builds result commands
`timescale 1ns / 1ps
`default_nettype none

module upd_front
    import upd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_final_byte,
    input  wire logic       i_plus_as_space,
    input  wire logic [1:0] i_stop_mode,
    output logic            o_cmd_valid,
    output t_cmd            o_cmd
);

    t_held      r_held;
    t_held      n_held;
    logic [7:0] r_held_byte;

    logic       c_hex;
    logic       tail_end;
    logic       tail_hold;
    t_res       tail_res;
    t_res       pct_res;
    t_res       held_res;
    t_res       dec_res;
    logic [7:0] dec_val;
    logic       dec_ok;
    logic [1:0] pre;
    logic       tail_present;
    logic [1:0] cnt;
    t_cmd       cmd;

    // shared classification of the incoming byte as lone text, plus the escape results
    always_comb begin
        c_hex     = is_hex(i_in_byte);
        tail_end  = (i_in_byte == CH_NUL)
                 || ((i_in_byte == CH_AMP) && (i_stop_mode != 2'd0))
                 || ((i_in_byte == CH_EQUALS) && i_stop_mode[1]);
        tail_hold = !tail_end && (i_in_byte == CH_PERCENT) && !i_final_byte;
        if (tail_end) begin
            tail_res = '{data: CH_NUL, byte_valid: 1'b0, token_end: 1'b1};
        end else if (i_plus_as_space && (i_in_byte == CH_PLUS)) begin
            tail_res = '{data: CH_SPACE, byte_valid: 1'b1, token_end: 1'b0};
        end else begin
            tail_res = '{data: i_in_byte, byte_valid: 1'b1, token_end: 1'b0};
        end
        pct_res  = '{data: CH_PERCENT, byte_valid: 1'b1, token_end: 1'b0};
        held_res = '{data: r_held_byte, byte_valid: 1'b1, token_end: 1'b0};
        dec_val  = {hex_nibble(r_held_byte), hex_nibble(i_in_byte)};
        dec_ok   = c_hex && (dec_val != 8'h00);
        dec_res  = '{data: dec_val, byte_valid: 1'b1, token_end: 1'b0};
    end

    // next state
    always_comb begin
        unique case (r_held)
            HELD_NONE: begin
                n_held = tail_hold ? HELD_PCT : HELD_NONE;
            end
            HELD_PCT: begin
                if (!i_final_byte && c_hex) begin
                    n_held = HELD_PCT_HEX;
                end else begin
                    n_held = tail_hold ? HELD_PCT : HELD_NONE;
                end
            end
            HELD_PCT_HEX: begin
                if (dec_ok) begin
                    n_held = HELD_NONE;
                end else begin
                    n_held = tail_hold ? HELD_PCT : HELD_NONE;
                end
            end
            default: begin
                n_held = HELD_NONE;
            end
        endcase
    end

    // outputs: decoded byte, or rejected escape bytes then the byte unless held
    always_comb begin
        pre          = 2'd0;
        tail_present = !tail_hold;
        unique case (r_held)
            HELD_NONE: begin
                pre = 2'd0;
            end
            HELD_PCT: begin
                if (!i_final_byte && c_hex) begin
                    tail_present = 1'b0;
                end else begin
                    pre = 2'd1;
                end
            end
            HELD_PCT_HEX: begin
                if (dec_ok) begin
                    tail_present = 1'b1;
                end else begin
                    pre = 2'd2;
                end
            end
            default: begin
                tail_present = 1'b0;
            end
        endcase

        cnt = pre + {1'b0, tail_present};

        cmd.res[0] = (pre == 2'd0) ? ((r_held == HELD_PCT_HEX) ? dec_res : tail_res)
                                   : pct_res;
        cmd.res[1] = (pre == 2'd1) ? tail_res : held_res;
        cmd.res[2] = tail_res;
        cmd.last   = cnt - 2'd1;
        // final flag closes the token on the last result
        for (int i = 0; i < 3; i++) begin
            if (i_final_byte && (cmd.last == 2'(i))) begin
                cmd.res[i].token_end = 1'b1;
            end
        end

        o_cmd_valid = i_accept && (cnt != 2'd0);
        o_cmd       = cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= HELD_NONE;
        end else if (i_accept) begin
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && (r_held == HELD_PCT)) begin
            r_held_byte <= i_in_byte;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/upd_cmd_queue.sv =====
// short queue of result commands between front and back end
`timescale 1ns / 1ps
`default_nettype none

module upd_cmd_queue
    import upd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/upd_back.sv =====
// back end: walks each command one result per cycle into the output register, while each result is popped
`timescale 1ns / 1ps
`default_nettype none

module upd_back
    import upd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    input  wire logic i_pop,
    output logic      o_empty,
    output logic [7:0] o_out_byte,
    output logic      o_byte_valid,
    output logic      o_token_end,
    output logic      o_run_last
);

    t_res       r_out;
    logic       r_out_last;
    logic       r_out_valid;
    logic [1:0] r_idx;
    t_res       sel;
    logic       is_last;
    logic       load;
    logic       taken;

    always_comb begin
        unique case (r_idx)
            2'd0:    sel = i_cmd.res[0];
            2'd1:    sel = i_cmd.res[1];
            2'd2:    sel = i_cmd.res[2];
            default: sel = i_cmd.res[2];
        endcase
        is_last   = (r_idx == i_cmd.last);
        taken     = i_pop && r_out_valid;
        // refill when empty or while the current result leaves
        load      = i_cmd_valid && (!r_out_valid || taken);
        o_cmd_pop = load && is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= is_last ? 2'd0 : (r_idx + 2'd1);
            end else if (taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out      <= sel;
            r_out_last <= is_last;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_out_byte   = r_out.data;
    assign o_byte_valid = r_out.byte_valid;
    assign o_token_end  = r_out.token_end;
    assign o_run_last   = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/url_percent_decoder.sv =====
// top level of the url percent decoder: config registers, front, queue, back
//
//  channel   direction  handshake           payload
//  input     in         push / full         i_in_byte, i_final_byte
//  result    out        empty / pop         o_out_byte, o_byte_valid, o_token_end, o_run_last
//  config    in         i_cfg_we            i_cfg_addr, i_cfg_wdata
//
// one byte is taken per cycle while full is low; the back end emits its results one by one
// a byte that only extends an open escape yields no result
// the command queue (QUEUE_DEPTH entries) absorbs bursts; full rises when all entries are taken
// a result reaches the ports through its queue entry and then the output register
// synchronous reset clears the open escape, the queue, the output valid flag and config
`timescale 1ns / 1ps
`default_nettype none

`include "url_percent_decoder_defines.svh"

module url_percent_decoder
    import upd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [7:0]            i_in_byte,
    input  wire logic                  i_final_byte,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [7:0]                 o_out_byte,
    output logic                       o_byte_valid,
    output logic                       o_token_end,
    output logic                       o_run_last,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic       r_plus_as_space;
    logic [1:0] r_stop_mode;
    logic       accept;
    logic       w_cmd_push;
    t_cmd       w_cmd_in;
    logic       w_q_valid;
    t_cmd       w_q_cmd;
    logic       w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plus_as_space <= 1'b0;
            r_stop_mode     <= 2'd0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_PLUS_AS_SPACE: r_plus_as_space <= i_cfg_wdata[0];
                CFG_STOP_MODE:     r_stop_mode     <= i_cfg_wdata[1:0];
                default:           r_stop_mode     <= r_stop_mode;
            endcase
        end
    end

    assign accept = push && !full;

    upd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_in_byte       (i_in_byte),
        .i_final_byte    (i_final_byte),
        .i_plus_as_space (r_plus_as_space),
        .i_stop_mode     (r_stop_mode),
        .o_cmd_valid     (w_cmd_push),
        .o_cmd           (w_cmd_in)
    );

    upd_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_cmd_in),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    upd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_q_valid),
        .i_cmd        (w_q_cmd),
        .o_cmd_pop    (w_q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_token_end  (o_token_end),
        .o_run_last   (o_run_last)
    );

    // a byteless result is always a token end marker
    `UPD_ASSERT_NOW(a_marker_shape, !empty && !o_byte_valid, o_token_end && (o_out_byte == 8'h00), "byteless result is not a clean token end")
    // the last byte of a text always produces at least one result
    `UPD_ASSERT_NEXT(a_final_makes_result, accept && i_final_byte, w_q_valid, "final byte left no command")
    // with a command waiting, the output register holds a result in the next cycle
    `UPD_ASSERT_NEXT(a_back_drains, w_q_valid, !empty, "back end did not pick up a waiting command")
    // full is only raised by an occupied queue
    `UPD_ASSERT_NOW(a_full_occupied, full, w_q_valid, "full raised with nothing queued")

endmodule

`default_nettype wire
